FILE: rtl/tisf_pkg.sv
// shared constants and types for the telnet iac stream filter
package tisf_pkg;

    localparam int BYTE_W = 8;

    // telnet command bytes
    localparam logic [BYTE_W-1:0] IAC  = 8'd255;
    localparam logic [BYTE_W-1:0] DONT = 8'd254;
    localparam logic [BYTE_W-1:0] DO   = 8'd253;
    localparam logic [BYTE_W-1:0] WONT = 8'd252;
    localparam logic [BYTE_W-1:0] WILL = 8'd251;

    // option codes answered after do
    localparam logic [BYTE_W-1:0] OPT_SUPPRESS_GA = 8'd3;
    localparam logic [BYTE_W-1:0] OPT_TIMING_MARK = 8'd6;
    localparam logic [BYTE_W-1:0] OPT_TERM_TYPE   = 8'd24;
    localparam logic [BYTE_W-1:0] OPT_WINDOW_SIZE = 8'd31;

    // output channel codes
    localparam logic CH_DATA  = 1'b0;
    localparam logic CH_REPLY = 1'b1;

    // reply beat positions
    localparam logic [1:0] BEAT_IAC  = 2'd0;
    localparam logic [1:0] BEAT_VERB = 2'd1;
    localparam logic [1:0] BEAT_OPT  = 2'd2;

    typedef enum logic [2:0] {
        ST_PLAIN = 3'b001,
        ST_CMD   = 3'b010,
        ST_OPT   = 3'b100
    } t_parse_state;

endpackage

FILE: rtl/tisf_in_if.sv
// input channel interface: one received byte per beat
interface tisf_in_if;
    logic                        valid;
    logic                        ready;
    logic [tisf_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/tisf_out_if.sv
// output channel interface: data or reply byte per beat
interface tisf_out_if;
    logic                        valid;
    logic                        ready;
    logic                        channel;
    logic [tisf_pkg::BYTE_W-1:0] out_byte;
    logic                        last;

    modport source (output valid, output channel, output out_byte, output last, input ready);
    modport sink   (input valid, input channel, input out_byte, input last, output ready);
endinterface

FILE: rtl/telnet_iac_stream_filter_core.sv
// telnet iac command filter: passes data bytes, answers do requests
//
//  port    dir  payload                       notes
//  ------  ---  ----------------------------  ---------------------------------
//  i_in    in   rx_byte[7:0]                  one byte from the telnet peer
//  o_out   out  channel, out_byte[7:0], last  0 = data to device, 1 = reply to peer
//
// one byte per cycle when no reply or o_out stall holds it: input register -> parser decode -> result register
// a data byte goes from the input register through the result register onto o_out;
// a reply takes three output beats, so the input stalls behind it
// (result register is the limit)
// command bytes that cause nothing retire even while the result register is busy
// the input register takes a new beat while a finished result waits on o_out
// synchronous active-low reset returns the parser to plain data, no pending do
module telnet_iac_stream_filter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tisf_in_if.sink     i_in,
    tisf_out_if.source  o_out
);

    // input register
    logic                        r_in_valid;
    logic [tisf_pkg::BYTE_W-1:0] r_in_byte;

    // parser state
    tisf_pkg::t_parse_state r_state;
    tisf_pkg::t_parse_state n_state;
    logic                   r_pending_do;
    logic                   n_pending_do;

    // result register
    logic                        r_out_valid;
    logic                        r_out_reply;
    logic                        r_out_will;
    logic [tisf_pkg::BYTE_W-1:0] r_out_byte;
    logic [1:0]                  r_beat;

    // decode of the byte in the input register
    logic emit_data;
    logic emit_reply;
    logic reply_will;
    logic has_result;

    // handshake helpers
    logic out_take;
    logic out_last;
    logic out_free;
    logic advance;
    logic load;
    logic in_take;

    // parser: next state and what this byte produces
    always_comb begin
        n_state      = r_state;
        n_pending_do = r_pending_do;
        emit_data    = 1'b0;
        emit_reply   = 1'b0;
        reply_will   = 1'b0;
        case (r_state)
            tisf_pkg::ST_CMD: begin
                if (r_in_byte == tisf_pkg::IAC) begin
                    // escaped iac iac is a literal data byte
                    n_state   = tisf_pkg::ST_PLAIN;
                    emit_data = 1'b1;
                end else if (r_in_byte inside {tisf_pkg::DO, tisf_pkg::DONT,
                                               tisf_pkg::WILL, tisf_pkg::WONT}) begin
                    n_pending_do = (r_in_byte == tisf_pkg::DO);
                    n_state      = tisf_pkg::ST_OPT;
                end else begin
                    // single-byte command, dropped
                    n_state = tisf_pkg::ST_PLAIN;
                end
            end
            tisf_pkg::ST_OPT: begin
                n_state = tisf_pkg::ST_PLAIN;
                if (r_pending_do) begin
                    if (r_in_byte inside {tisf_pkg::OPT_SUPPRESS_GA,
                                          tisf_pkg::OPT_TIMING_MARK}) begin
                        emit_reply = 1'b1;
                        reply_will = 1'b1;
                    end else if (r_in_byte inside {tisf_pkg::OPT_TERM_TYPE,
                                                   tisf_pkg::OPT_WINDOW_SIZE}) begin
                        emit_reply = 1'b1;
                    end
                end
            end
            default: begin
                // plain data
                if (r_in_byte == tisf_pkg::IAC) begin
                    n_state = tisf_pkg::ST_CMD;
                end else begin
                    n_state   = tisf_pkg::ST_PLAIN;
                    emit_data = 1'b1;
                end
            end
        endcase
    end

    assign has_result = emit_data | emit_reply;

    // output side: last beat of a reply is the option byte
    assign out_last = !r_out_reply || (r_beat == tisf_pkg::BEAT_OPT);
    assign out_take = r_out_valid && o_out.ready;
    assign out_free = !r_out_valid || (out_take && out_last);

    // a byte with no result retires at once; otherwise it waits for a free result register
    assign advance = r_in_valid && (!has_result || out_free);
    assign load    = advance && has_result;

    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    always_comb begin
        if (!r_out_reply) begin
            o_out.out_byte = r_out_byte;
        end else begin
            case (r_beat)
                tisf_pkg::BEAT_IAC:  o_out.out_byte = tisf_pkg::IAC;
                tisf_pkg::BEAT_VERB: o_out.out_byte = r_out_will ? tisf_pkg::WILL
                                                                 : tisf_pkg::WONT;
                default:             o_out.out_byte = r_out_byte;
            endcase
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.channel = r_out_reply ? tisf_pkg::CH_REPLY : tisf_pkg::CH_DATA;
    assign o_out.last    = out_last;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_state      <= tisf_pkg::ST_PLAIN;
            r_pending_do <= 1'b0;
            r_out_valid  <= 1'b0;
            r_beat       <= tisf_pkg::BEAT_IAC;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_state      <= n_state;
                r_pending_do <= n_pending_do;
            end

            if (load) begin
                r_out_valid <= 1'b1;
                r_beat      <= tisf_pkg::BEAT_IAC;
            end else if (out_take) begin
                if (out_last) begin
                    r_out_valid <= 1'b0;
                end else begin
                    r_beat <= r_beat + 2'd1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in.rx_byte;
        end
        if (load) begin
            r_out_reply <= emit_reply;
            r_out_will  <= reply_will;
            r_out_byte  <= r_in_byte;
        end
    end

    // a reply, once started, continues on the next beat without data interleaved
    a_reply_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.channel && !o_out.last)
        |=> (o_out.valid && o_out.channel))
        else $error("reply beats interrupted");

    // data beats are always single-beat results
    a_data_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.channel) |-> o_out.last)
        else $error("data beat without last");

    // the closing reply beat carries one of the answered options
    a_reply_option: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.channel && o_out.last)
        |-> (o_out.out_byte == tisf_pkg::OPT_SUPPRESS_GA
             || o_out.out_byte == tisf_pkg::OPT_TIMING_MARK
             || o_out.out_byte == tisf_pkg::OPT_TERM_TYPE
             || o_out.out_byte == tisf_pkg::OPT_WINDOW_SIZE))
        else $error("reply option out of set");

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the telnet iac stream filter core
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                        channel;
        logic [tisf_pkg::BYTE_W-1:0] out_byte;
        logic                        last;
    } t_out_beat;

    // how a directed row is checked: typed expectation or the parser model
    typedef enum logic [1:0] {
        ROW_SILENT,
        ROW_DATA,
        ROW_REPLY,
        ROW_PREDICT
    } t_row_kind;

    typedef struct packed {
        logic [tisf_pkg::BYTE_W-1:0] rx;
        t_row_kind                   kind;
        logic [tisf_pkg::BYTE_W-1:0] verb;
    } t_dir_row;

    localparam int DIR_ROWS     = 24;
    localparam int RAND_BYTES   = 400;
    localparam int HOLD_AT_BEAT = 150;
    localparam int HOLD_CYCLES  = 100;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 16;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tisf_in_if  in_ch ();
    tisf_out_if out_ch ();

    telnet_iac_stream_filter_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // parser model state
    tisf_pkg::t_parse_state      parse_st = tisf_pkg::ST_PLAIN;
    logic [tisf_pkg::BYTE_W-1:0] pend_cmd = '0;

    t_out_beat out_due[$];
    int        accepted_cnt = 0;
    int        fault_cnt    = 0;
    int        burst_left   = 0;

    t_dir_row dir_table [DIR_ROWS] = '{
        '{8'h00,                     ROW_DATA,    8'h00},  // lowest data byte
        '{tisf_pkg::IAC,             ROW_SILENT,  8'h00},
        '{tisf_pkg::IAC,             ROW_DATA,    8'h00},  // escaped iac comes out as data
        '{tisf_pkg::IAC,             ROW_PREDICT, 8'h00},
        '{tisf_pkg::DO,              ROW_SILENT,  8'h00},
        '{tisf_pkg::OPT_SUPPRESS_GA, ROW_REPLY,   tisf_pkg::WILL},
        '{tisf_pkg::IAC,             ROW_PREDICT, 8'h00},
        '{tisf_pkg::DO,              ROW_PREDICT, 8'h00},
        '{tisf_pkg::OPT_TIMING_MARK, ROW_REPLY,   tisf_pkg::WILL},
        '{tisf_pkg::IAC,             ROW_PREDICT, 8'h00},
        '{tisf_pkg::DO,              ROW_PREDICT, 8'h00},
        '{tisf_pkg::OPT_TERM_TYPE,   ROW_REPLY,   tisf_pkg::WONT},
        '{tisf_pkg::IAC,             ROW_PREDICT, 8'h00},
        '{tisf_pkg::DO,              ROW_PREDICT, 8'h00},
        '{tisf_pkg::OPT_WINDOW_SIZE, ROW_REPLY,   tisf_pkg::WONT},
        '{tisf_pkg::IAC,             ROW_PREDICT, 8'h00},  // unknown option after do
        '{tisf_pkg::DO,              ROW_PREDICT, 8'h00},
        '{8'h01,                     ROW_SILENT,  8'h00},
        '{tisf_pkg::IAC,             ROW_PREDICT, 8'h00},  // known option after a non-do command
        '{tisf_pkg::WONT,            ROW_PREDICT, 8'h00},
        '{tisf_pkg::OPT_SUPPRESS_GA, ROW_SILENT,  8'h00},
        '{tisf_pkg::IAC,             ROW_PREDICT, 8'h00},  // single-byte command is dropped
        '{8'hF1,                     ROW_SILENT,  8'h00},
        '{8'hFE,                     ROW_DATA,    8'h00}   // high data byte
    };

    function automatic bit is_opt_cmd(input logic [tisf_pkg::BYTE_W-1:0] b);
        return (b == tisf_pkg::DO) || (b == tisf_pkg::DONT) || (b == tisf_pkg::WILL)
            || (b == tisf_pkg::WONT);
    endfunction

    // advance the parser model by one byte; queue its results when asked
    function automatic void parse_rx_byte(input logic [tisf_pkg::BYTE_W-1:0] b,
                                          input bit emit);
        t_out_beat                   res [3];
        int                          n;
        logic [tisf_pkg::BYTE_W-1:0] verb;
        n    = 0;
        verb = tisf_pkg::WILL;
        case (parse_st)
            tisf_pkg::ST_CMD: begin
                if (b == tisf_pkg::IAC) begin
                    parse_st = tisf_pkg::ST_PLAIN;
                    res[0]   = '{tisf_pkg::CH_DATA, b, 1'b1};
                    n        = 1;
                end else if (is_opt_cmd(b)) begin
                    pend_cmd = b;
                    parse_st = tisf_pkg::ST_OPT;
                end else begin
                    parse_st = tisf_pkg::ST_PLAIN;
                end
            end
            tisf_pkg::ST_OPT: begin
                parse_st = tisf_pkg::ST_PLAIN;
                if (pend_cmd == tisf_pkg::DO) begin
                    if (b == tisf_pkg::OPT_SUPPRESS_GA || b == tisf_pkg::OPT_TIMING_MARK) begin
                        verb = tisf_pkg::WILL;
                        n    = 3;
                    end else if (b == tisf_pkg::OPT_TERM_TYPE
                                 || b == tisf_pkg::OPT_WINDOW_SIZE) begin
                        verb = tisf_pkg::WONT;
                        n    = 3;
                    end
                    if (n == 3) begin
                        res[0] = '{tisf_pkg::CH_REPLY, tisf_pkg::IAC, 1'b0};
                        res[1] = '{tisf_pkg::CH_REPLY, verb, 1'b0};
                        res[2] = '{tisf_pkg::CH_REPLY, b, 1'b1};
                    end
                end
            end
            default: begin
                if (b == tisf_pkg::IAC) begin
                    parse_st = tisf_pkg::ST_CMD;
                end else begin
                    parse_st = tisf_pkg::ST_PLAIN;
                    res[0]   = '{tisf_pkg::CH_DATA, b, 1'b1};
                    n        = 1;
                end
            end
        endcase
        if (emit) begin
            for (int i = 0; i < n; i++) out_due.push_back(res[i]);
        end
    endfunction

    function automatic void log_fault(input string msg);
        fault_cnt++;
        if (fault_cnt <= 10) $display("%0t: mismatch: %s", $realtime, msg);
    endfunction

    // offer one byte in the current burst, wait for the beat, record expectations
    task automatic send_byte(input logic [tisf_pkg::BYTE_W-1:0] b, input t_row_kind kind,
                             input logic [tisf_pkg::BYTE_W-1:0] verb);
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 16);
        end
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        accepted_cnt++;
        burst_left--;
        parse_rx_byte(b, kind == ROW_PREDICT);
        case (kind)
            ROW_DATA:  out_due.push_back('{tisf_pkg::CH_DATA, b, 1'b1});
            ROW_REPLY: begin
                out_due.push_back('{tisf_pkg::CH_REPLY, tisf_pkg::IAC, 1'b0});
                out_due.push_back('{tisf_pkg::CH_REPLY, verb, 1'b0});
                out_due.push_back('{tisf_pkg::CH_REPLY, b, 1'b1});
            end
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // mostly well-formed telnet traffic, with some stray bytes to break sequences
    task automatic send_random_seq();
        int                          pick;
        logic [tisf_pkg::BYTE_W-1:0] cmd;
        logic [tisf_pkg::BYTE_W-1:0] opt;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            send_byte(8'($urandom_range(0, 254)), ROW_PREDICT, 8'h00);
        end else if (pick < 50) begin
            send_byte(tisf_pkg::IAC, ROW_PREDICT, 8'h00);
            send_byte(tisf_pkg::IAC, ROW_PREDICT, 8'h00);
        end else if (pick < 85) begin
            case ($urandom_range(0, 5))
                0:       cmd = tisf_pkg::DONT;
                1:       cmd = tisf_pkg::WILL;
                2:       cmd = tisf_pkg::WONT;
                default: cmd = tisf_pkg::DO;
            endcase
            case ($urandom_range(0, 7))
                0:       opt = tisf_pkg::OPT_SUPPRESS_GA;
                1:       opt = tisf_pkg::OPT_TIMING_MARK;
                2:       opt = tisf_pkg::OPT_TERM_TYPE;
                3:       opt = tisf_pkg::OPT_WINDOW_SIZE;
                4:       opt = tisf_pkg::OPT_SUPPRESS_GA;
                5:       opt = tisf_pkg::OPT_WINDOW_SIZE;
                default: opt = 8'($urandom_range(0, 255));
            endcase
            send_byte(tisf_pkg::IAC, ROW_PREDICT, 8'h00);
            send_byte(cmd, ROW_PREDICT, 8'h00);
            send_byte(opt, ROW_PREDICT, 8'h00);
        end else if (pick < 93) begin
            // single-byte commands sit below the option verbs
            send_byte(tisf_pkg::IAC, ROW_PREDICT, 8'h00);
            send_byte(8'($urandom_range(0, 250)), ROW_PREDICT, 8'h00);
        end else begin
            send_byte(8'($urandom_range(0, 255)), ROW_PREDICT, 8'h00);
        end
    endtask

    // sender: reset, directed table, random traffic, drain and verdict
    initial begin
        int drain;
        in_ch.valid   = 1'b0;
        in_ch.rx_byte = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (dir_table[i]) begin
            send_byte(dir_table[i].rx, dir_table[i].kind, dir_table[i].verb);
        end
        while (accepted_cnt < DIR_ROWS + RAND_BYTES) send_random_seq();
        in_ch.valid <= 1'b0;
        drain = 0;
        while (out_due.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_cnt == 0 && out_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // receiver: segments of full rate, a repeating stall mask, or random stalls,
    // plus one long hold-off so the block backs up into its input
    initial begin
        int          seg_len;
        int          mode;
        logic [15:0] mask;
        bit          held;
        out_ch.ready = 1'b0;
        held         = 1'b0;
        forever begin
            if (!held && accepted_cnt >= HOLD_AT_BEAT) begin
                held = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    out_ch.ready <= 1'b0;
                end
            end
            mode    = $urandom_range(0, 2);
            seg_len = $urandom_range(8, 40);
            mask    = 16'($urandom_range(0, 65535)) | 16'h0001;
            for (int c = 0; c < seg_len; c++) begin
                @(negedge i_clk);
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= mask[c % 16];
                    default: out_ch.ready <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    // compare each output beat with the oldest expected one
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (out_due.size() == 0) begin
                log_fault($sformatf("unexpected beat ch=%0d byte=%02h last=%0d",
                                    out_ch.channel, out_ch.out_byte, out_ch.last));
            end else begin
                want = out_due.pop_front();
                if (out_ch.channel !== want.channel || out_ch.out_byte !== want.out_byte
                        || out_ch.last !== want.last) begin
                    log_fault($sformatf(
                        "exp ch=%0d byte=%02h last=%0d, got ch=%0d byte=%02h last=%0d",
                        want.channel, want.out_byte, want.last,
                        out_ch.channel, out_ch.out_byte, out_ch.last));
                end
            end
        end
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #2_400_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/tisf_pkg.sv
rtl/tisf_in_if.sv
rtl/tisf_out_if.sv
rtl/telnet_iac_stream_filter_core.sv
tb/tb_top.sv
